// ===== rtl/core/pidfd_pkg.sv =====
// shared widths, codes and saturation helper for the filtered-derivative pid block
`default_nettype none

package pidfd_pkg;

	localparam int SampleW  = 16;
	localparam int DiffW    = 17;
	localparam int TermW    = 32;
	localparam int GainW    = 24;
	localparam int LimW     = 31;
	localparam int AlphaW   = 17;
	localparam int InvW     = 24;
	localparam int AccW     = 34;
	localparam int MulAW    = 34;
	localparam int MulBW    = 25;
	localparam int ProdW    = MulAW + MulBW;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 31;
	localparam int OpW      = 2;

	localparam logic [AlphaW-1:0] AlphaOne = AlphaW'(65536);

	localparam logic [OpW-1:0] OpSample    = 2'd0;
	localparam logic [OpW-1:0] OpClrInteg  = 2'd1;
	localparam logic [OpW-1:0] OpClrDeriv  = 2'd2;

	localparam logic [CfgIdxW-1:0] CfgFilterMode = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgPropGain   = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgIntegGain  = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgDerivGain  = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgIntegLimit = 3'd4;
	localparam logic [CfgIdxW-1:0] CfgAlpha      = 3'd5;
	localparam logic [CfgIdxW-1:0] CfgInvPeriod  = 3'd6;

	function automatic logic signed [TermW-1:0] sat32(input logic signed [ProdW-1:0] x);
		logic [ProdW-TermW:0] hi;
		hi = x[ProdW-1:TermW-1];
		if ((&hi) || !(|hi))
			return x[TermW-1:0];
		else if (x[ProdW-1])
			return {1'b1, {(TermW-1){1'b0}}};
		else
			return {1'b0, {(TermW-1){1'b1}}};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pid_filtered_derivative.sv =====
// pid controller with low-pass filtered derivative, top level
// a new sample runs through the multiply states before reaching ST_DONE, and a clear
// or unused opcode goes straight to ST_DONE, which holds until the output is free
// input is taken only in ST_IDLE, so each sample or clear ends before the next one;
// the single 34x25 multiplier is used five times in sequence per sample
// reset: all state, held terms, outputs and config go to zero, alpha_q to 65536
`default_nettype none

module pid_filtered_derivative (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_we,
	input  wire logic [pidfd_pkg::CfgIdxW-1:0]           cfg_index,
	input  wire logic [pidfd_pkg::CfgDataW-1:0]          cfg_data,
	input  wire logic                                    in_valid,
	output      logic                                    in_ready,
	input  wire logic [pidfd_pkg::OpW-1:0]               opcode,
	input  wire logic signed [pidfd_pkg::SampleW-1:0]    sample,
	output      logic                                    out_valid,
	input  wire logic                                    out_ready,
	output      logic signed [pidfd_pkg::TermW-1:0]      p_term,
	output      logic signed [pidfd_pkg::TermW-1:0]      i_term,
	output      logic signed [pidfd_pkg::TermW-1:0]      d_term,
	output      logic signed [pidfd_pkg::TermW-1:0]      integ_value
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_DIFF,
		ST_RAW,
		ST_MUL_FILT,
		ST_DERIV0,
		ST_MUL_CHG,
		ST_CHG,
		ST_MUL_CDER,
		ST_DERIV1,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_WR_D,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic                                      mode_q;
	logic signed [pidfd_pkg::GainW-1:0]        pgain_q;
	logic signed [pidfd_pkg::GainW-1:0]        igain_q;
	logic signed [pidfd_pkg::GainW-1:0]        dgain_q;
	logic [pidfd_pkg::LimW-1:0]                ilim_q;
	logic [pidfd_pkg::AlphaW-1:0]              alpha_q;
	logic [pidfd_pkg::InvW-1:0]                inv_q;

	// controller state
	logic signed [pidfd_pkg::SampleW-1:0]      last_q;
	logic signed [pidfd_pkg::TermW-1:0]        deriv_q;
	logic signed [pidfd_pkg::TermW-1:0]        integ_q;
	logic signed [pidfd_pkg::TermW-1:0]        held_p_q;
	logic signed [pidfd_pkg::TermW-1:0]        held_i_q;
	logic signed [pidfd_pkg::TermW-1:0]        held_d_q;

	// working registers
	logic signed [pidfd_pkg::SampleW-1:0]      sample_q;
	logic signed [pidfd_pkg::AccW-1:0]         acc_q;

	logic                                      out_valid_q;
	logic signed [pidfd_pkg::TermW-1:0]        p_term_q;
	logic signed [pidfd_pkg::TermW-1:0]        i_term_q;
	logic signed [pidfd_pkg::TermW-1:0]        d_term_q;
	logic signed [pidfd_pkg::TermW-1:0]        integ_out_q;

	logic [pidfd_pkg::AlphaW-1:0]              alpha_eff;
	logic signed [pidfd_pkg::DiffW-1:0]        diff;
	logic signed [pidfd_pkg::MulAW-1:0]        mul_a;
	logic signed [pidfd_pkg::MulBW-1:0]        mul_b;
	logic signed [pidfd_pkg::ProdW-1:0]        prod;
	logic signed [pidfd_pkg::ProdW-1:0]        prod_sh8;
	logic signed [pidfd_pkg::ProdW-1:0]        prod_sh16;
	logic signed [pidfd_pkg::TermW-1:0]        raw;
	logic signed [pidfd_pkg::AccW-1:0]         raw_step;
	logic signed [pidfd_pkg::ProdW-1:0]        deriv_sum;
	logic signed [pidfd_pkg::DiffW-1:0]        chg;
	logic signed [pidfd_pkg::DiffW-1:0]        last_next;
	logic signed [pidfd_pkg::AccW-1:0]         integ_sum;
	logic signed [pidfd_pkg::AccW-1:0]         lim_pos;
	logic signed [pidfd_pkg::AccW-1:0]         lim_neg;
	logic signed [pidfd_pkg::AccW-1:0]         integ_clamped;
	logic                                      in_xfer;
	logic                                      out_free;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_xfer     = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;
	assign p_term      = p_term_q;
	assign i_term      = i_term_q;
	assign d_term      = d_term_q;
	assign integ_value = integ_out_q;

	assign alpha_eff = (alpha_q > pidfd_pkg::AlphaOne) ? pidfd_pkg::AlphaOne : alpha_q;
	assign diff      = {sample_q[pidfd_pkg::SampleW-1], sample_q}
	                 - {last_q[pidfd_pkg::SampleW-1], last_q};

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_DIFF, ST_MUL_CHG: begin
				mul_a = {{(pidfd_pkg::MulAW-pidfd_pkg::DiffW){diff[pidfd_pkg::DiffW-1]}}, diff};
				if (state_q == ST_MUL_DIFF)
					mul_b = {1'b0, inv_q};
				else
					mul_b = {{(pidfd_pkg::MulBW-pidfd_pkg::AlphaW){1'b0}}, alpha_eff};
			end
			ST_MUL_FILT: begin
				mul_a = acc_q;
				mul_b = {{(pidfd_pkg::MulBW-pidfd_pkg::AlphaW){1'b0}}, alpha_eff};
			end
			ST_MUL_CDER: begin
				mul_a = acc_q;
				mul_b = {1'b0, inv_q};
			end
			ST_MUL_P, ST_MUL_I: begin
				mul_a = {{(pidfd_pkg::MulAW-pidfd_pkg::SampleW){last_q[pidfd_pkg::SampleW-1]}},
				         last_q};
				if (state_q == ST_MUL_P)
					mul_b = {pgain_q[pidfd_pkg::GainW-1], pgain_q};
				else
					mul_b = {igain_q[pidfd_pkg::GainW-1], igain_q};
			end
			ST_MUL_D: begin
				mul_a = {{(pidfd_pkg::MulAW-pidfd_pkg::TermW){deriv_q[pidfd_pkg::TermW-1]}},
				         deriv_q};
				mul_b = {dgain_q[pidfd_pkg::GainW-1], dgain_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pidfd_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	assign prod_sh8  = prod >>> 8;
	assign prod_sh16 = prod >>> 16;
	assign raw       = pidfd_pkg::sat32(prod_sh8);
	assign raw_step  = {{(pidfd_pkg::AccW-pidfd_pkg::TermW){raw[pidfd_pkg::TermW-1]}}, raw}
	                 - {{(pidfd_pkg::AccW-pidfd_pkg::TermW){deriv_q[pidfd_pkg::TermW-1]}},
	                    deriv_q};
	assign deriv_sum = {{(pidfd_pkg::ProdW-pidfd_pkg::TermW){deriv_q[pidfd_pkg::TermW-1]}},
	                    deriv_q} + prod_sh16;
	assign chg       = prod_sh16[pidfd_pkg::DiffW-1:0];
	assign last_next = {last_q[pidfd_pkg::SampleW-1], last_q} + chg;
	assign integ_sum = {{(pidfd_pkg::AccW-pidfd_pkg::TermW){integ_q[pidfd_pkg::TermW-1]}},
	                    integ_q} + prod_sh16[pidfd_pkg::AccW-1:0];
	assign lim_pos   = {{(pidfd_pkg::AccW-pidfd_pkg::LimW){1'b0}}, ilim_q};
	assign lim_neg   = -lim_pos;

	always_comb begin
		if (acc_q < lim_neg)
			integ_clamped = lim_neg;
		else if (acc_q > lim_pos)
			integ_clamped = lim_pos;
		else
			integ_clamped = acc_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			pgain_q <= '0;
			igain_q <= '0;
			dgain_q <= '0;
			ilim_q  <= '0;
			alpha_q <= pidfd_pkg::AlphaOne;
			inv_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pidfd_pkg::CfgFilterMode: mode_q  <= cfg_data[0];
				pidfd_pkg::CfgPropGain:   pgain_q <= cfg_data[pidfd_pkg::GainW-1:0];
				pidfd_pkg::CfgIntegGain:  igain_q <= cfg_data[pidfd_pkg::GainW-1:0];
				pidfd_pkg::CfgDerivGain:  dgain_q <= cfg_data[pidfd_pkg::GainW-1:0];
				pidfd_pkg::CfgIntegLimit: ilim_q  <= cfg_data[pidfd_pkg::LimW-1:0];
				pidfd_pkg::CfgAlpha:      alpha_q <= cfg_data[pidfd_pkg::AlphaW-1:0];
				pidfd_pkg::CfgInvPeriod:  inv_q   <= cfg_data[pidfd_pkg::InvW-1:0];
				default: ;
			endcase
		end
	end

	// input capture and scratch accumulator
	always_ff @(posedge clk) begin
		if (in_xfer)
			sample_q <= sample;
		case (state_q)
			ST_RAW:   acc_q <= raw_step;
			ST_CHG:   acc_q <= {{(pidfd_pkg::AccW-pidfd_pkg::DiffW){chg[pidfd_pkg::DiffW-1]}}, chg};
			ST_MUL_D: acc_q <= integ_sum;
			default:  ;
		endcase
	end

	// sequencer, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= '0;
			deriv_q     <= '0;
			integ_q     <= '0;
			held_p_q    <= '0;
			held_i_q    <= '0;
			held_d_q    <= '0;
			out_valid_q <= 1'b0;
			p_term_q    <= '0;
			i_term_q    <= '0;
			d_term_q    <= '0;
			integ_out_q <= '0;
		end else begin
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (opcode == pidfd_pkg::OpSample) begin
							state_q <= mode_q ? ST_MUL_CHG : ST_MUL_DIFF;
						end else begin
							if (opcode == pidfd_pkg::OpClrInteg)
								integ_q <= '0;
							if (opcode == pidfd_pkg::OpClrDeriv)
								deriv_q <= '0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL_DIFF: state_q <= ST_RAW;
				ST_RAW:      state_q <= ST_MUL_FILT;
				ST_MUL_FILT: state_q <= ST_DERIV0;
				ST_DERIV0: begin
					if (inv_q != '0)
						deriv_q <= pidfd_pkg::sat32(deriv_sum);
					last_q  <= sample_q;
					state_q <= ST_MUL_P;
				end
				ST_MUL_CHG: state_q <= ST_CHG;
				ST_CHG: begin
					last_q  <= last_next[pidfd_pkg::SampleW-1:0];
					state_q <= ST_MUL_CDER;
				end
				ST_MUL_CDER: state_q <= ST_DERIV1;
				ST_DERIV1: begin
					if (inv_q != '0)
						deriv_q <= raw;
					state_q <= ST_MUL_P;
				end
				ST_MUL_P: state_q <= ST_MUL_I;
				ST_MUL_I: begin
					held_p_q <= pidfd_pkg::sat32(prod_sh16);
					state_q  <= ST_MUL_D;
				end
				ST_MUL_D: state_q <= ST_WR_D;
				ST_WR_D: begin
					held_d_q <= pidfd_pkg::sat32(prod_sh16);
					if (igain_q != '0) begin
						integ_q  <= integ_clamped[pidfd_pkg::TermW-1:0];
						held_i_q <= integ_clamped[pidfd_pkg::TermW-1:0];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						p_term_q    <= held_p_q;
						i_term_q    <= held_i_q;
						d_term_q    <= held_d_q;
						integ_out_q <= integ_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample path reaches ST_DONE without waiting on any handshake
	a_sample_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && opcode == pidfd_pkg::OpSample) |-> ##9 (state_q == ST_DONE))
		else $error("sample sequence length mismatch");

	// clear integrator transfer empties the integrator
	a_clr_integ: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && opcode == pidfd_pkg::OpClrInteg) |=> (integ_q == '0))
		else $error("integrator not cleared");

	// integrator stays inside the clamp after an update
	a_integ_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR_D && igain_q != '0) |=>
		(($signed({integ_q[pidfd_pkg::TermW-1], integ_q}) <= $signed({2'b00, ilim_q})) &&
		 ($signed({integ_q[pidfd_pkg::TermW-1], integ_q}) >= -$signed({2'b00, ilim_q}))))
		else $error("integrator outside limit");

	// i term held while integration is disabled
	a_i_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR_D && igain_q == '0) |=> $stable(held_i_q))
		else $error("i term changed with integration disabled");

endmodule

`default_nettype wire

// ===== rtl/core/pidfd_mul.sv =====
// shared signed multiplier with registered product
`default_nettype none

module pidfd_mul (
	input  wire logic                                  clk,
	input  wire logic signed [pidfd_pkg::MulAW-1:0]    a,
	input  wire logic signed [pidfd_pkg::MulBW-1:0]    b,
	output      logic signed [pidfd_pkg::ProdW-1:0]    prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

`default_nettype wire
